@@ rtl/mld_pkg.sv @@
package mld_pkg;

    // Pipeline depth: front end, six lift stages overlapping the root
    // recurrence (twelve stages, two root bits each), five drag stages.
    localparam int NSTAGE = 19;
    localparam int SQ_LAST = 13;

    // Register indexes of the write port
    localparam logic [2:0] CFG_LIFT_GAIN   = 3'd0;
    localparam logic [2:0] CFG_DRAG_GAIN   = 3'd1;
    localparam logic [2:0] CFG_TILT_SCALE  = 3'd2;
    localparam logic [2:0] CFG_GROUND_TURN = 3'd3;
    localparam logic [2:0] CFG_FORCE_KIND  = 3'd4;

    localparam logic [22:0] LIFT_GAIN_RST = 23'd65536;
    localparam logic [16:0] DRAG_GAIN_RST = 17'd328;
    localparam logic [22:0] TILT_RST      = 23'd65536;
    localparam logic [6:0]  TICK_SCALE    = 7'd120;

    typedef struct packed {
        logic signed [23:0] vel_x;
        logic signed [23:0] vel_y;
        logic signed [23:0] vel_z;
        logic signed [23:0] spin_x;
        logic signed [23:0] spin_y;
        logic signed [23:0] spin_z;
        logic        [15:0] tick_seconds;
    } in_t;

    typedef struct packed {
        logic signed [31:0] lift_x;
        logic signed [31:0] lift_y;
        logic signed [31:0] lift_z;
        logic signed [31:0] drag_x;
        logic signed [31:0] drag_y;
        logic signed [31:0] drag_z;
        logic               drag_apply;
        logic        [2:0]  force_kind_out;
    } out_t;

    // Digit-recurrence square root state
    typedef struct packed {
        logic [47:0] n;
        logic [26:0] rem;
        logic [23:0] root;
    } sq_t;

    typedef struct packed {
        logic [2:0][23:0]      v;
        logic [1:0][46:0]      tmag;
        logic [1:0]            tneg;
        logic [2:0][31:0]      spin;
        logic                  ground;
        logic [2:0][46:0]      vsq;
        logic [45:0]           lk;
        logic [39:0]           dk;
        logic [5:0][55:0]      prod;
        logic [2:0][55:0]      crm;
        logic [2:0]            crn;
        logic [2:0][3:0][50:0] lpp;
        logic [2:0][1:0][73:0] lrow;
        logic [2:0][103:0]     ltot;
        logic [2:0][31:0]      lift;
        sq_t                   sq;
        logic [2:0][47:0]      dm;
        logic [2:0]            dn;
        logic [2:0][3:0][43:0] dpp;
        logic [2:0][1:0][63:0] drow;
        logic [2:0][88:0]      dtot;
        logic [2:0][31:0]      drag;
    } pipe_t;

    function automatic logic [23:0] abs24(logic [23:0] s);
        return s[23] ? (24'd0 - s) : s;
    endfunction

    function automatic logic signed [55:0] smul(logic signed [31:0] a,
                                                logic signed [23:0] b);
        return 56'(a) * 56'(b);
    endfunction

    // One root bit: bring down two radicand bits, try, subtract
    function automatic sq_t sqrt_step(sq_t s);
        sq_t         r;
        logic [26:0] rt;
        logic [26:0] trial;
        rt    = {s.rem[24:0], s.n[47:46]};
        trial = {1'b0, s.root, 2'b01};
        r.n   = {s.n[45:0], 2'b00};
        if (rt >= trial) begin
            r.rem  = rt - trial;
            r.root = {s.root[22:0], 1'b1};
        end else begin
            r.rem  = rt;
            r.root = {s.root[22:0], 1'b0};
        end
        return r;
    endfunction

    // Cap magnitude at the Q23.8 limit for its sign, then apply the sign
    function automatic logic [31:0] sat32(logic [63:0] q, logic neg);
        logic [63:0] lim;
        logic [63:0] m;
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        m   = (q > lim) ? lim : q;
        return neg ? (32'd0 - m[31:0]) : m[31:0];
    endfunction

endpackage

@@ rtl/magnus_lift_and_drag_force.sv @@
// Magnus lift and quadratic drag force engine, one ball per beat.
// Input channel s_valid/s_ready/s_data carries velocity, spin and tick
// length; result channel m_valid/m_ready/m_data carries the two saturated
// Q23.8 force vectors, the airborne flag and the configured force kind.
// Registers are written through cfg_we/cfg_index/cfg_wdata; the user must
// write them only while no beat is in flight, which the block does not
// enforce. Indexes past the last register are ignored. Throughput: one
// beat per cycle until a stalled receiver fills the pipeline. Depth is set
// by the speed magnitude square root, a 24-step digit recurrence laid out
// two steps per stage over twelve stages, with the lift products running
// beside it and the drag products (split into partial products) following
// it. Each stage holds its beat until the next one frees up, so a stalled
// receiver fills empty stages first and s_ready drops only when every
// stage holds a beat. Reset empties the pipeline and restores the
// register defaults: lift and tilt gain 1.0, drag gain 328, ground turn
// off, force kind 0.
module magnus_lift_and_drag_force import mld_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_t         s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_t        m_data,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [22:0] cfg_wdata
);

    logic [22:0] lift_gain_reg;
    logic [16:0] drag_gain_reg;
    logic [22:0] tilt_reg;
    logic        ground_turn_reg;
    logic [2:0]  force_kind_reg;

    pipe_t              pipe_reg  [NSTAGE];
    pipe_t              pipe_next [NSTAGE];
    logic [NSTAGE-1:0]  vld_reg;
    logic [NSTAGE-1:0]  vld_next;
    logic [NSTAGE-1:0]  en;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lift_gain_reg   <= LIFT_GAIN_RST;
            drag_gain_reg   <= DRAG_GAIN_RST;
            tilt_reg        <= TILT_RST;
            ground_turn_reg <= 1'b0;
            force_kind_reg  <= 3'd0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_LIFT_GAIN:   lift_gain_reg   <= cfg_wdata;
                CFG_DRAG_GAIN:   drag_gain_reg   <= cfg_wdata[16:0];
                CFG_TILT_SCALE:  tilt_reg        <= cfg_wdata;
                CFG_GROUND_TURN: ground_turn_reg <= cfg_wdata[0];
                CFG_FORCE_KIND:  force_kind_reg  <= cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    // Advance a stage when it is empty or its successor advances
    always_comb begin
        en[NSTAGE-1] = ~vld_reg[NSTAGE-1] | m_ready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            en[k] = ~vld_reg[k] | en[k+1];
        end
        vld_next[0] = en[0] ? s_valid : vld_reg[0];
        for (int k = 1; k < NSTAGE; k++) begin
            vld_next[k] = en[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    assign s_ready = en[0];
    assign m_valid = vld_reg[NSTAGE-1];

    // Stage datapath
    always_comb begin
        pipe_t       p;
        pipe_t       n;
        logic [47:0] rnd;
        logic [31:0] smag;
        logic signed [55:0] cr;
        logic [23:0] vm;

        // Front end: spin tilt products, velocity squares, gain * dt
        n = '0;
        n.v[0] = s_data.vel_x;
        n.v[1] = s_data.vel_y;
        n.v[2] = s_data.vel_z;
        n.tmag[0] = {23'd0, abs24(s_data.spin_x)} * {24'd0, tilt_reg};
        n.tmag[1] = {23'd0, abs24(s_data.spin_y)} * {24'd0, tilt_reg};
        n.tneg[0] = s_data.spin_x[23];
        n.tneg[1] = s_data.spin_y[23];
        n.spin[2] = {{8{s_data.spin_z[23]}}, s_data.spin_z};
        n.ground  = (s_data.vel_z == 24'sd0);
        for (int i = 0; i < 3; i++) begin
            vm = abs24(n.v[i]);
            n.vsq[i] = 47'({24'd0, vm} * {24'd0, vm});
        end
        n.lk = 46'(lift_gain_reg) * 46'(s_data.tick_seconds);
        n.dk = 40'(drag_gain_reg) * 40'(s_data.tick_seconds);
        pipe_next[0] = n;

        for (int k = 1; k < NSTAGE; k++) begin
            p = pipe_reg[k-1];
            n = p;
            if (k == 1) begin
                // Round scaled spin, clear it on the ground, sum squares
                for (int i = 0; i < 2; i++) begin
                    rnd = 48'(p.tmag[i]) + 48'h8000;
                    smag = rnd[47:16];
                    n.spin[i] = p.tneg[i] ? (32'd0 - smag) : smag;
                    if (p.ground) n.spin[i] = '0;
                end
                if (p.ground && !ground_turn_reg) n.spin[2] = '0;
                n.sq.n    = 48'(p.vsq[0]) + 48'(p.vsq[1]) + 48'(p.vsq[2]);
                n.sq.rem  = '0;
                n.sq.root = '0;
                n.lk = p.lk * 46'(TICK_SCALE);
                n.dk = p.dk * 40'(TICK_SCALE);
            end
            if (k >= 2 && k <= SQ_LAST) begin
                n.sq = sqrt_step(sqrt_step(p.sq));
            end
            if (k == 2) begin
                // Cross product terms
                n.prod[0] = smul(p.spin[1], p.v[2]);
                n.prod[1] = smul(p.spin[2], p.v[1]);
                n.prod[2] = smul(p.spin[2], p.v[0]);
                n.prod[3] = smul(p.spin[0], p.v[2]);
                n.prod[4] = smul(p.spin[0], p.v[1]);
                n.prod[5] = smul(p.spin[1], p.v[0]);
            end
            if (k == 3) begin
                for (int i = 0; i < 3; i++) begin
                    cr = $signed(p.prod[2*i]) - $signed(p.prod[2*i+1]);
                    n.crn[i] = cr[55];
                    n.crm[i] = cr[55] ? (56'd0 - cr) : cr;
                end
            end
            if (k == 4) begin
                for (int i = 0; i < 3; i++) begin
                    n.lpp[i][0] = 51'(p.crm[i][27:0])  * 51'(p.lk[22:0]);
                    n.lpp[i][1] = 51'(p.crm[i][27:0])  * 51'(p.lk[45:23]);
                    n.lpp[i][2] = 51'(p.crm[i][55:28]) * 51'(p.lk[22:0]);
                    n.lpp[i][3] = 51'(p.crm[i][55:28]) * 51'(p.lk[45:23]);
                end
            end
            if (k == 5) begin
                for (int i = 0; i < 3; i++) begin
                    n.lrow[i][0] = 74'(p.lpp[i][0]) + (74'(p.lpp[i][1]) << 23);
                    n.lrow[i][1] = 74'(p.lpp[i][2]) + (74'(p.lpp[i][3]) << 23);
                end
            end
            if (k == 6) begin
                for (int i = 0; i < 3; i++) begin
                    n.ltot[i] = 104'(p.lrow[i][0]) + (104'(p.lrow[i][1]) << 28)
                              + (104'd1 << 47);
                end
            end
            if (k == 7) begin
                for (int i = 0; i < 3; i++) begin
                    n.lift[i] = sat32(64'(p.ltot[i][103:48]), p.crn[i]);
                end
            end
            if (k == SQ_LAST + 1) begin
                // Speed times velocity, sign flipped for drag
                for (int i = 0; i < 3; i++) begin
                    vm = abs24(p.v[i]);
                    n.dm[i] = 48'(p.sq.root) * 48'(vm);
                    n.dn[i] = ~p.v[i][23];
                end
            end
            if (k == SQ_LAST + 2) begin
                for (int i = 0; i < 3; i++) begin
                    n.dpp[i][0] = 44'(p.dm[i][23:0])  * 44'(p.dk[19:0]);
                    n.dpp[i][1] = 44'(p.dm[i][23:0])  * 44'(p.dk[39:20]);
                    n.dpp[i][2] = 44'(p.dm[i][47:24]) * 44'(p.dk[19:0]);
                    n.dpp[i][3] = 44'(p.dm[i][47:24]) * 44'(p.dk[39:20]);
                end
            end
            if (k == SQ_LAST + 3) begin
                for (int i = 0; i < 3; i++) begin
                    n.drow[i][0] = 64'(p.dpp[i][0]) + (64'(p.dpp[i][1]) << 20);
                    n.drow[i][1] = 64'(p.dpp[i][2]) + (64'(p.dpp[i][3]) << 20);
                end
            end
            if (k == SQ_LAST + 4) begin
                for (int i = 0; i < 3; i++) begin
                    n.dtot[i] = 89'(p.drow[i][0]) + (89'(p.drow[i][1]) << 24)
                              + (89'd1 << 39);
                end
            end
            if (k == SQ_LAST + 5) begin
                for (int i = 0; i < 3; i++) begin
                    n.drag[i] = sat32(64'(p.dtot[i][88:40]), p.dn[i]);
                end
            end
            pipe_next[k] = n;
        end
    end

    // Valid bits and stage payloads
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NSTAGE; k++) begin
            if (en[k]) pipe_reg[k] <= pipe_next[k];
        end
    end

    // Result beat
    assign m_data.lift_x         = pipe_reg[NSTAGE-1].lift[0];
    assign m_data.lift_y         = pipe_reg[NSTAGE-1].lift[1];
    assign m_data.lift_z         = pipe_reg[NSTAGE-1].lift[2];
    assign m_data.drag_x         = pipe_reg[NSTAGE-1].drag[0];
    assign m_data.drag_y         = pipe_reg[NSTAGE-1].drag[1];
    assign m_data.drag_z         = pipe_reg[NSTAGE-1].drag[2];
    assign m_data.drag_apply     = ~pipe_reg[NSTAGE-1].ground;
    assign m_data.force_kind_out = force_kind_reg;

    // A full pipeline with a stalled receiver takes no new beat
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (&vld_reg) && !m_ready |-> !s_ready)
        else $error("input accepted while pipeline full and stalled");

    // An accepted beat always lands in the first stage
    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[0])
        else $error("accepted beat lost at pipeline entry");

    // A grounded ball without ground turning has no spin, hence no lift
    a_ground_lift: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.drag_apply && !ground_turn_reg |->
        (m_data.lift_x == 32'sd0) && (m_data.lift_y == 32'sd0) &&
        (m_data.lift_z == 32'sd0))
        else $error("nonzero lift for a grounded ball");

endmodule
